FILE: rtl/wtl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package wtl_pkg;

  // Width of the byte position counter; offsets and lengths leave the block at 16 bits.
  localparam int POS_BITS  = 16;
  localparam int CALC_BITS = (POS_BITS + 1 > 17) ? POS_BITS + 1 : 17;
  localparam int OUT_BITS  = 16;

  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_EQUAL   = 8'h3D;
  localparam logic [7:0] CH_LESS    = 8'h3C;
  localparam logic [7:0] CH_GREATER = 8'h3E;
  localparam logic [7:0] CH_BANG    = 8'h21;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  localparam logic [1:0] OP_LESS    = 2'd0;
  localparam logic [1:0] OP_GREATER = 2'd1;
  localparam logic [1:0] OP_BANG    = 2'd2;
  localparam logic [1:0] OP_ASSIGN  = 2'd3;

  localparam logic [3:0] KIND_WORD   = 4'd0;
  localparam logic [3:0] KIND_STRING = 4'd1;
  localparam logic [3:0] KIND_ERROR  = 4'd10;

  typedef struct packed {
    logic [3:0]          kind;
    logic [OUT_BITS-1:0] start;
    logic [OUT_BITS-1:0] length;
    logic                run_last;
    logic                text_done;
    logic                overflow;
  } token_t;

  // Single operator kind; the paired form with '=' is one above it.
  function automatic logic [3:0] op_kind(input logic [1:0] code);
    op_kind = {1'b0, code, 1'b0} + 4'd2;
  endfunction

  function automatic logic [OUT_BITS-1:0] sat16(input logic [CALC_BITS-1:0] x);
    sat16 = (x > CALC_BITS'(16'hFFFF)) ? 16'hFFFF : x[OUT_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/whitespace_token_lexer.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake          Payload
// in_       input      in_valid/in_stall  in_text_byte, in_end_of_text
// out_      output     out_valid/out_stall token kind, start, length, run_last,
//                                          text_done, position_overflow
//
// One byte per cycle while the input register does not hold: a byte is registered,
// decoded against the scan state in one pass and its 0..2 tokens are written into a
// 4-entry output queue. A byte passes the input register and then the output queue
// before its first token is offered on out_.
// The input register holds while the queue has fewer than two free entries.
// Reset (rst_n low, synchronous) returns the scanner to idle at offset zero;
// the end-of-text byte does the same after its tokens are queued.

module whitespace_token_lexer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_text_byte,
  input  wire logic        in_end_of_text,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [3:0]       out_token_kind,
  output logic [15:0]      out_token_start,
  output logic [15:0]      out_token_length,
  output logic             out_run_last,
  output logic             out_text_done,
  output logic             out_position_overflow
);

  localparam logic [1:0] MODE_IDLE   = 2'd0;
  localparam logic [1:0] MODE_WORD   = 2'd1;
  localparam logic [1:0] MODE_STRING = 2'd2;
  localparam logic [1:0] MODE_OP     = 2'd3;

  localparam int PB = wtl_pkg::POS_BITS;
  localparam int CB = wtl_pkg::CALC_BITS;
  localparam logic [PB-1:0] POS_MAX = {PB{1'b1}};

  // input register
  logic             s1_valid_r;
  logic [7:0]       s1_byte_r;
  logic             s1_end_r;
  logic             fire;

  // scan state
  logic [1:0]       mode_r, mode_nxt;
  logic [1:0]       pend_r, pend_nxt;
  logic [PB-1:0]    begin_r, begin_nxt;
  logic [PB-1:0]    pos_r, pos_nxt;
  logic             ovf_r, ovf_nxt;

  // output queue
  wtl_pkg::token_t  q_r [4];
  logic [1:0]       wr_ptr_r, rd_ptr_r;
  logic [2:0]       q_cnt_r;
  logic             pop;

  wtl_pkg::token_t  tok0, tok1;
  logic             emit0, emit1;

  assign fire     = s1_valid_r && (q_cnt_r <= 3'd2);
  assign in_stall = s1_valid_r && !fire;
  assign pop      = (q_cnt_r != 3'd0) && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_byte_r <= in_text_byte;
      s1_end_r  <= in_end_of_text;
    end
  end

  always_comb begin
    logic             is_sp, is_q, is_eq, op_hit;
    logic [1:0]       op_code;
    logic [PB:0]      p1;
    logic [PB-1:0]    p1_sat;
    logic [CB-1:0]    len_pb, len_p1b;
    logic             st_emit;
    wtl_pkg::token_t  st_tok;
    logic [1:0]       st_mode, st_pend;
    logic [PB-1:0]    st_begin;

    is_sp   = (s1_byte_r == wtl_pkg::CH_SPACE) || (s1_byte_r == wtl_pkg::CH_NEWLINE);
    is_q    = (s1_byte_r == wtl_pkg::CH_QUOTE);
    is_eq   = (s1_byte_r == wtl_pkg::CH_EQUAL);
    op_hit  = 1'b1;
    op_code = wtl_pkg::OP_LESS;
    case (s1_byte_r)
      wtl_pkg::CH_LESS:    op_code = wtl_pkg::OP_LESS;
      wtl_pkg::CH_GREATER: op_code = wtl_pkg::OP_GREATER;
      wtl_pkg::CH_BANG:    op_code = wtl_pkg::OP_BANG;
      wtl_pkg::CH_EQUAL:   op_code = wtl_pkg::OP_ASSIGN;
      default:             op_hit  = 1'b0;
    endcase

    p1      = {1'b0, pos_r} + (PB + 1)'(1);
    p1_sat  = p1[PB] ? POS_MAX : p1[PB-1:0];
    len_pb  = (pos_r >= begin_r) ? CB'(pos_r - begin_r) : '0;
    len_p1b = (p1 >= {1'b0, begin_r}) ? CB'(p1 - {1'b0, begin_r}) : '0;

    // a byte opening a new token, from idle or right after a single operator
    st_emit          = s1_end_r && !is_sp;
    st_tok.kind      = is_q ? wtl_pkg::KIND_ERROR :
                       op_hit ? wtl_pkg::op_kind(op_code) : wtl_pkg::KIND_WORD;
    st_tok.start     = wtl_pkg::sat16(CB'(is_q ? p1_sat : pos_r));
    st_tok.length    = is_q ? 16'd0 : 16'd1;
    st_tok.run_last  = 1'b0;
    st_tok.text_done = 1'b0;
    st_tok.overflow  = ovf_r;
    st_mode          = is_sp ? MODE_IDLE : is_q ? MODE_STRING : op_hit ? MODE_OP : MODE_WORD;
    st_begin         = is_sp ? begin_r : is_q ? p1_sat : pos_r;
    st_pend          = (op_hit && !is_sp && !is_q) ? op_code : pend_r;

    tok0           = st_tok;
    tok1           = st_tok;
    emit0          = 1'b0;
    emit1          = 1'b0;
    mode_nxt       = mode_r;
    pend_nxt       = pend_r;
    begin_nxt      = begin_r;

    unique case (mode_r)
      MODE_OP: begin
        emit0        = 1'b1;
        tok0.start   = wtl_pkg::sat16(CB'(begin_r));
        mode_nxt     = MODE_IDLE;
        if (is_eq) begin
          tok0.kind   = wtl_pkg::op_kind(pend_r) + 4'd1;
          tok0.length = 16'd2;
        end else begin
          tok0.kind   = wtl_pkg::op_kind(pend_r);
          tok0.length = 16'd1;
          emit1       = st_emit;
          mode_nxt    = st_mode;
          begin_nxt   = st_begin;
          pend_nxt    = st_pend;
        end
      end
      MODE_WORD, MODE_STRING: begin
        tok0.kind  = (mode_r == MODE_WORD) ? wtl_pkg::KIND_WORD : wtl_pkg::KIND_STRING;
        tok0.start = wtl_pkg::sat16(CB'(begin_r));
        if ((mode_r == MODE_WORD) ? is_sp : is_q) begin
          emit0       = 1'b1;
          tok0.length = wtl_pkg::sat16(len_pb);
          mode_nxt    = MODE_IDLE;
        end else if (s1_end_r) begin
          emit0       = 1'b1;
          tok0.length = wtl_pkg::sat16(len_p1b);
          if (mode_r == MODE_STRING) begin
            tok0.kind = wtl_pkg::KIND_ERROR;
          end
        end
      end
      default: begin
        emit0     = st_emit;
        mode_nxt  = st_mode;
        begin_nxt = st_begin;
        pend_nxt  = st_pend;
      end
    endcase

    tok0.run_last  = !emit1;
    tok0.text_done = !emit1 && s1_end_r;
    tok1.run_last  = 1'b1;
    tok1.text_done = s1_end_r;

    ovf_nxt = ovf_r;
    pos_nxt = p1[PB-1:0];
    if (s1_end_r) begin
      mode_nxt  = MODE_IDLE;
      pend_nxt  = wtl_pkg::OP_LESS;
      begin_nxt = '0;
      pos_nxt   = '0;
      ovf_nxt   = 1'b0;
    end else if (pos_r == POS_MAX) begin
      pos_nxt = POS_MAX;
      ovf_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      pend_r  <= wtl_pkg::OP_LESS;
      begin_r <= '0;
      pos_r   <= '0;
      ovf_r   <= 1'b0;
    end else if (fire) begin
      mode_r  <= mode_nxt;
      pend_r  <= pend_nxt;
      begin_r <= begin_nxt;
      pos_r   <= pos_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit0) begin
      q_r[wr_ptr_r] <= tok0;
    end
    if (fire && emit1) begin
      q_r[wr_ptr_r + 2'd1] <= tok1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      q_cnt_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + ((fire && emit0) ? (emit1 ? 2'd2 : 2'd1) : 2'd0);
      rd_ptr_r <= rd_ptr_r + {1'b0, pop};
      q_cnt_r  <= q_cnt_r + ((fire && emit0) ? (emit1 ? 3'd2 : 3'd1) : 3'd0)
                  - {2'b0, pop};
    end
  end

  assign out_valid             = (q_cnt_r != 3'd0);
  assign out_token_kind        = q_r[rd_ptr_r].kind;
  assign out_token_start       = q_r[rd_ptr_r].start;
  assign out_token_length      = q_r[rd_ptr_r].length;
  assign out_run_last          = q_r[rd_ptr_r].run_last;
  assign out_text_done         = q_r[rd_ptr_r].text_done;
  assign out_position_overflow = q_r[rd_ptr_r].overflow;

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt_r <= 3'd4)
    else $error("output queue overrun");

  a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
    fire && s1_end_r |=> pos_r == '0 && mode_r == MODE_IDLE && !ovf_r)
    else $error("scan state not cleared after end of text");

  a_pos_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    fire && !s1_end_r |=> pos_r >= $past(pos_r))
    else $error("byte position went backwards");

  a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r && !(fire && s1_end_r) |=> ovf_r)
    else $error("overflow flag dropped inside a text");

  a_second_needs_first: assert property (@(posedge clk) disable iff (!rst_n)
    fire && emit1 |-> emit0 && mode_r == MODE_OP)
    else $error("second token without an operator flush");

endmodule

`default_nettype wire

FILE: tb/tb_whitespace_token_lexer.sv
`timescale 1ns / 1ps

module tb_whitespace_token_lexer;

  localparam logic [3:0] TOK_LESS       = 4'd2;
  localparam logic [3:0] TOK_LESS_EQ    = 4'd3;
  localparam logic [3:0] TOK_GREATER    = 4'd4;
  localparam logic [3:0] TOK_GREATER_EQ = 4'd5;
  localparam logic [3:0] TOK_NOT        = 4'd6;
  localparam logic [3:0] TOK_NOT_EQ     = 4'd7;
  localparam logic [3:0] TOK_ASSIGN     = 4'd8;
  localparam logic [3:0] TOK_EQUAL      = 4'd9;

  localparam longint unsigned POS_MAX = (64'd1 << wtl_pkg::POS_BITS) - 64'd1;
  localparam int STUCK_LIMIT = 1000;
  localparam int HOLD_CYCLES = 80;

  typedef enum logic [1:0] {SCAN_IDLE, SCAN_WORD, SCAN_STRING, SCAN_OP} scan_e;

  typedef struct {
    logic [7:0] ch;
    logic       fin;
    bit         pause_here;
  } byte_item_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_text_byte = 8'h00;
  logic        in_end_of_text = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  out_token_kind;
  logic [15:0] out_token_start;
  logic [15:0] out_token_length;
  logic        out_run_last;
  logic        out_text_done;
  logic        out_position_overflow;

  whitespace_token_lexer dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_text_byte          (in_text_byte),
    .in_end_of_text        (in_end_of_text),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_token_kind        (out_token_kind),
    .out_token_start       (out_token_start),
    .out_token_length      (out_token_length),
    .out_run_last          (out_run_last),
    .out_text_done         (out_text_done),
    .out_position_overflow (out_position_overflow)
  );

  always #5 clk = ~clk;

  // Scanner state mirrored in the testbench
  scan_e           lex_mode = SCAN_IDLE;
  logic [1:0]      lex_op = wtl_pkg::OP_LESS;
  longint unsigned lex_begin = 0;
  longint unsigned lex_pos = 0;
  logic            lex_ovf = 1'b0;

  wtl_pkg::token_t step_toks[$];
  wtl_pkg::token_t tokens_due[$];
  byte_item_t      text_q[$];

  int  errors = 0;
  int  bytes_taken = 0;
  int  texts_taken = 0;
  int  tokens_seen = 0;
  int  ovf_tokens = 0;
  int  pair_steps = 0;
  int  stuck = 0;
  int  cyc = 0;
  int  tx_gap = 0;
  int  rx_gap = 0;
  int  hold_left = 0;
  bit  held = 1'b0;
  bit  calm = 1'b0;

  function automatic logic [15:0] clip16(input longint unsigned x);
    return (x > 64'd65535) ? 16'hFFFF : x[15:0];
  endfunction

  function automatic longint unsigned clip_pos(input longint unsigned x);
    return (x > POS_MAX) ? POS_MAX : x;
  endfunction

  function automatic bit op_code_of(input logic [7:0] c, output logic [1:0] code);
    code = wtl_pkg::OP_LESS;
    case (c)
      wtl_pkg::CH_LESS:    code = wtl_pkg::OP_LESS;
      wtl_pkg::CH_GREATER: code = wtl_pkg::OP_GREATER;
      wtl_pkg::CH_BANG:    code = wtl_pkg::OP_BANG;
      wtl_pkg::CH_EQUAL:   code = wtl_pkg::OP_ASSIGN;
      default:             return 1'b0;
    endcase
    return 1'b1;
  endfunction

  function automatic logic [3:0] tok_single(input logic [1:0] code);
    case (code)
      wtl_pkg::OP_LESS:    return TOK_LESS;
      wtl_pkg::OP_GREATER: return TOK_GREATER;
      wtl_pkg::OP_BANG:    return TOK_NOT;
      default:             return TOK_ASSIGN;
    endcase
  endfunction

  function automatic logic [3:0] tok_paired(input logic [1:0] code);
    case (code)
      wtl_pkg::OP_LESS:    return TOK_LESS_EQ;
      wtl_pkg::OP_GREATER: return TOK_GREATER_EQ;
      wtl_pkg::OP_BANG:    return TOK_NOT_EQ;
      default:             return TOK_EQUAL;
    endcase
  endfunction

  function automatic bit is_blank(input logic [7:0] c);
    return c == wtl_pkg::CH_SPACE || c == wtl_pkg::CH_NEWLINE;
  endfunction

  task automatic add_tok(input logic [3:0] kind, input longint unsigned s,
                         input longint unsigned len);
    wtl_pkg::token_t t;
    t.kind      = kind;
    t.start     = clip16(s);
    t.length    = clip16(len);
    t.run_last  = 1'b0;
    t.text_done = 1'b0;
    t.overflow  = lex_ovf;
    step_toks.push_back(t);
  endtask

  // A byte seen between tokens; with fin set it closes the token at once.
  task automatic open_token(input logic [7:0] c, input bit fin, input longint unsigned p);
    logic [1:0] code;
    if (is_blank(c)) return;
    if (c == wtl_pkg::CH_QUOTE) begin
      lex_begin = clip_pos(p + 1);
      lex_mode  = SCAN_STRING;
      if (fin) add_tok(wtl_pkg::KIND_ERROR, lex_begin, 0);
      return;
    end
    lex_begin = p;
    if (op_code_of(c, code)) begin
      lex_op   = code;
      lex_mode = SCAN_OP;
      if (fin) add_tok(tok_single(code), p, 1);
    end else begin
      lex_mode = SCAN_WORD;
      if (fin) add_tok(wtl_pkg::KIND_WORD, p, 1);
    end
  endtask

  task automatic lex_step(input logic [7:0] c, input bit fin);
    longint unsigned p;
    longint unsigned b;
    int n;
    p = lex_pos;
    b = lex_begin;
    step_toks.delete();
    case (lex_mode)
      SCAN_OP: begin
        lex_mode = SCAN_IDLE;
        if (c == wtl_pkg::CH_EQUAL) begin
          add_tok(tok_paired(lex_op), b, 2);
        end else begin
          add_tok(tok_single(lex_op), b, 1);
          open_token(c, fin, p);
        end
      end
      SCAN_WORD: begin
        if (is_blank(c)) begin
          add_tok(wtl_pkg::KIND_WORD, b, (p >= b) ? p - b : 0);
          lex_mode = SCAN_IDLE;
        end else if (fin) begin
          add_tok(wtl_pkg::KIND_WORD, b, (p + 1 >= b) ? p + 1 - b : 0);
        end
      end
      SCAN_STRING: begin
        if (c == wtl_pkg::CH_QUOTE) begin
          add_tok(wtl_pkg::KIND_STRING, b, (p >= b) ? p - b : 0);
          lex_mode = SCAN_IDLE;
        end else if (fin) begin
          add_tok(wtl_pkg::KIND_ERROR, b, (p + 1 >= b) ? p + 1 - b : 0);
        end
      end
      default: open_token(c, fin, p);
    endcase
    n = step_toks.size();
    if (n > 0) begin
      step_toks[n-1].run_last = 1'b1;
      if (fin) step_toks[n-1].text_done = 1'b1;
    end
    if (n > 1) pair_steps++;
    foreach (step_toks[i]) tokens_due.push_back(step_toks[i]);
    if (fin) begin
      lex_mode  = SCAN_IDLE;
      lex_op    = wtl_pkg::OP_LESS;
      lex_begin = 0;
      lex_pos   = 0;
      lex_ovf   = 1'b0;
    end else if (p >= POS_MAX) begin
      lex_pos = POS_MAX;
      lex_ovf = 1'b1;
    end else begin
      lex_pos = p + 1;
    end
  endtask

  // ---------------- stimulus generation ----------------

  function automatic logic [7:0] word_byte();
    logic [7:0] c;
    logic [1:0] code;
    do c = 8'($urandom_range(0, 255));
    while (is_blank(c) || c == wtl_pkg::CH_QUOTE || op_code_of(c, code));
    return c;
  endfunction

  function automatic logic [7:0] string_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c == wtl_pkg::CH_QUOTE);
    return c;
  endfunction

  function automatic logic [7:0] op_byte();
    case ($urandom_range(0, 3))
      0:       return wtl_pkg::CH_LESS;
      1:       return wtl_pkg::CH_GREATER;
      2:       return wtl_pkg::CH_BANG;
      default: return wtl_pkg::CH_EQUAL;
    endcase
  endfunction

  task automatic push_byte(input logic [7:0] ch, input logic fin);
    byte_item_t it;
    it.ch = ch;
    it.fin = fin;
    it.pause_here = 1'b0;
    text_q.push_back(it);
  endtask

  task automatic push_pause();
    byte_item_t it;
    it.ch = 8'h00;
    it.fin = 1'b0;
    it.pause_here = 1'b1;
    text_q.push_back(it);
  endtask

  task automatic push_str(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i], i == s.len() - 1);
  endtask

  // Mostly well-formed tokens, a little noise; the tail is sometimes clipped
  // so that texts also end inside strings and right after operators.
  task automatic push_rand_text(input int min_len);
    logic [7:0] txt[$];
    int n;
    int cut;
    while (txt.size() < min_len) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          n = $urandom_range(1, 6);
          txt.push_back(word_byte());
          repeat (n - 1) begin
            if ($urandom_range(0, 5) == 0)
              txt.push_back(($urandom_range(0, 1) == 0) ? wtl_pkg::CH_QUOTE : op_byte());
            else
              txt.push_back(word_byte());
          end
        end
        4, 5: begin
          txt.push_back(wtl_pkg::CH_QUOTE);
          n = $urandom_range(0, 5);
          repeat (n) txt.push_back(string_byte());
          txt.push_back(wtl_pkg::CH_QUOTE);
        end
        6, 7: begin
          txt.push_back(op_byte());
          if ($urandom_range(0, 1) == 1) txt.push_back(wtl_pkg::CH_EQUAL);
        end
        8: txt.push_back(8'($urandom_range(0, 255)));
        default: repeat ($urandom_range(1, 3))
          txt.push_back(($urandom_range(0, 1) == 0) ? wtl_pkg::CH_SPACE :
                                                       wtl_pkg::CH_NEWLINE);
      endcase
      if ($urandom_range(0, 3) != 0)
        txt.push_back(($urandom_range(0, 1) == 0) ? wtl_pkg::CH_SPACE :
                                                     wtl_pkg::CH_NEWLINE);
    end
    cut = $urandom_range(0, 2);
    while (cut > 0 && txt.size() > 1) begin
      void'(txt.pop_back());
      cut--;
    end
    foreach (txt[i]) push_byte(txt[i], i == txt.size() - 1);
  endtask

  task automatic push_random_bytes(input int amount);
    int start_size;
    start_size = text_q.size();
    while (text_q.size() - start_size < amount) push_rand_text($urandom_range(1, 30));
  endtask

  // ---------------- driver ----------------

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_gap <= 0;
    end else begin
      calm <= (text_q.size() < 150);
      if (in_valid && !in_stall) begin
        lex_step(in_text_byte, in_end_of_text);
        bytes_taken++;
        if (in_end_of_text) texts_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (tx_gap > 0) begin
          in_valid <= 1'b0;
          tx_gap <= tx_gap - 1;
        end else if (text_q.size() == 0) begin
          in_valid <= 1'b0;
        end else if (text_q[0].pause_here) begin
          // drain point: resume once every predicted token has come out
          in_valid <= 1'b0;
          if (tokens_due.size() == 0) void'(text_q.pop_front());
        end else if (!calm && !cyc[8] && $urandom_range(0, 7) == 0) begin
          in_valid <= 1'b0;
          tx_gap <= $urandom_range(0, 4);
        end else begin
          in_valid <= 1'b1;
          in_text_byte <= text_q[0].ch;
          in_end_of_text <= text_q[0].fin;
          void'(text_q.pop_front());
        end
      end
    end
  end

  // ---------------- receiver backpressure ----------------

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_gap <= 0;
      hold_left <= 0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!held && bytes_taken >= 100) begin
      // one long hold-off so the output queue fills and the input backs up
      held <= 1'b1;
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
    end else if (rx_gap > 0) begin
      out_stall <= 1'b1;
      rx_gap <= rx_gap - 1;
    end else if (!calm && !cyc[7] && $urandom_range(0, 7) == 0) begin
      out_stall <= 1'b1;
      rx_gap <= $urandom_range(0, 4);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // ---------------- monitor ----------------

  task automatic note_fail(input string msg);
    errors++;
    if (errors <= 10) $display("mismatch: %s", msg);
  endtask

  always @(posedge clk) begin
    wtl_pkg::token_t got;
    wtl_pkg::token_t want;
    if (rst_n && out_valid && !out_stall) begin
      got.kind      = out_token_kind;
      got.start     = out_token_start;
      got.length    = out_token_length;
      got.run_last  = out_run_last;
      got.text_done = out_text_done;
      got.overflow  = out_position_overflow;
      tokens_seen++;
      if (got.overflow) ovf_tokens++;
      if (tokens_due.size() == 0) begin
        note_fail($sformatf("token %0d arrived with none predicted (kind %0d start %0d)",
                            tokens_seen, got.kind, got.start));
      end else begin
        want = tokens_due.pop_front();
        if (got.kind !== want.kind || got.start !== want.start ||
            got.length !== want.length || got.run_last !== want.run_last ||
            got.text_done !== want.text_done || got.overflow !== want.overflow)
          note_fail($sformatf({"token %0d got/exp: kind %0d/%0d start %0d/%0d len %0d/%0d",
                               " last %b/%b done %b/%b ovf %b/%b"},
                              tokens_seen, got.kind, want.kind, got.start, want.start,
                              got.length, want.length, got.run_last, want.run_last,
                              got.text_done, want.text_done, got.overflow, want.overflow));
      end
    end
  end

  // ---------------- watchdog ----------------

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck <= 0;
    end else if (stuck >= STUCK_LIMIT) begin
      $display("no transaction for %0d cycles, %0d tokens still expected",
               STUCK_LIMIT, tokens_due.size());
      $display("TB_ERROR");
      $finish;
    end else begin
      stuck <= stuck + 1;
    end
  end

  // ---------------- test sequence ----------------

  initial begin
    // operators, pairs, quote inside a word
    push_str("<=>!=x\"s\"");
    // assign ended by newline, closed string, operator followed by operator at end
    push_str("=\n\"ab\" <!");
    push_str(">===");
    // whitespace only: no token at all
    push_str(" \n");
    // end inside a string, empty and with one byte
    push_str("\"");
    push_byte(wtl_pkg::CH_QUOTE, 1'b0);
    push_byte(8'hFF, 1'b1);
    push_pause();

    push_random_bytes(400);
    push_pause();

    push_random_bytes(420);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    wait (text_q.size() == 0 && !in_valid && tokens_due.size() == 0);
    repeat (20) @(posedge clk);
    errors += tokens_due.size();

    $display("lexed %0d bytes in %0d texts, checked %0d tokens", bytes_taken, texts_taken,
             tokens_seen);
    $display("%0d tokens after position saturation, %0d bytes gave two tokens, %0d errors",
             ovf_tokens, pair_steps, errors);
    if (errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

FILE: whitespace_token_lexer.f
rtl/wtl_pkg.sv
rtl/whitespace_token_lexer.sv
tb/tb_whitespace_token_lexer.sv
